/* sv/geodetic_to_ecef_assert.svh */
// Assertion macros shared by the geodetic to ECEF converter.
`ifndef GEODETIC_TO_ECEF_ASSERT_SVH
`define GEODETIC_TO_ECEF_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define G2E_ASSERT_IMPL(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define G2E_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/g2e_pkg.sv */
// Shared constants, types and elaboration-time table functions of the converter.
`default_nettype none
package g2e_pkg;

  localparam int CORDIC_STAGES_DEF = 32;
  localparam int NEWTON_STEPS      = 8;
  localparam int MUL_LAT           = 4;

  localparam int ANG_W      = 32;
  localparam int H_W        = 28;
  localparam int COORD_W    = 34;
  localparam int AXIS_W     = 33;
  localparam int ECC_W      = 32;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 104;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 33;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SEMI_MAJOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECC_SQ     = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_RESET = 33'd6378137000;
  localparam logic [ECC_W-1:0]  ECC_RESET  = 32'd28752143;
  localparam logic [ECC_W-1:0]  ECC_LIMIT  = 32'h8000_0000;

  localparam logic signed [63:0] ONE_Q60    = 64'sh1000_0000_0000_0000;
  localparam logic signed [63:0] THREE_Q60  = 64'sh3000_0000_0000_0000;
  localparam logic signed [63:0] HALF_Q60   = 64'sh0800_0000_0000_0000;
  localparam logic [63:0]        INV_PI_Q64 = 64'h517C_C1B7_2722_0A95;
  localparam logic signed [63:0] OUT_LIMIT  = 64'sd8000000000;

  // Signed product scaled down by 2^s, truncated toward zero, magnitude clamped.
  function automatic logic signed [63:0] smul_c(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input int s);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] pr;
    neg = a[63] ^ b[63];
    ua  = a[63] ? (64'd0 - 64'(a)) : 64'(a);
    ub  = b[63] ? (64'd0 - 64'(b)) : 64'(b);
    pr  = ({64'd0, ua} * {64'd0, ub}) >> s;
    if (pr > {65'd0, {63{1'b1}}}) begin
      pr = {65'd0, {63{1'b1}}};
    end
    return neg ? (64'sd0 - $signed(pr[63:0])) : $signed(pr[63:0]);
  endfunction

  // Restoring long division, used only while building tables.
  function automatic logic [63:0] udiv_c(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Inverse square root in Q60 by a fixed count of Newton steps.
  function automatic logic signed [63:0] inv_sqrt_c(input logic signed [63:0] w,
                                                    input logic signed [63:0] y0);
    logic signed [63:0] y;
    logic signed [63:0] y2;
    logic signed [63:0] wy2;
    y = y0;
    for (int k = 0; k < NEWTON_STEPS; k++) begin
      y2  = smul_c(y, y, 60);
      wy2 = smul_c(w, y2, 60);
      y   = smul_c(y, THREE_Q60 - wy2, 61);
    end
    return y;
  endfunction

  // Rotation angle of one CORDIC stage, pi = 2^61.
  function automatic logic signed [63:0] cordic_atan(input int i);
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [127:0] pr;
    int           e;
    acc = '0;
    if (i == 0) begin
      return HALF_Q60;
    end
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = udiv_c(64'd1 << (62 - e), 64'(2 * k + 1));
        if ((k & 1) != 0) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    pr = {64'd0, acc} * {64'd0, INV_PI_Q64};
    return $signed({1'b0, pr[127:65]});
  endfunction

  // Start vector of the CORDIC, the inverse of its gain in Q60.
  function automatic logic signed [63:0] cordic_inv_gain(input int stages);
    logic signed [63:0] g;
    g = ONE_Q60;
    for (int i = 0; i < 64; i++) begin
      if (i < stages && 2 * i < 64) begin
        g = g + (g >>> (2 * i));
      end
    end
    return inv_sqrt_c(g, HALF_Q60);
  endfunction

endpackage
`default_nettype wire

/* sv/g2e_mul.sv */
// Pipelined 64 by 64 signed multiply with constant down-scale and saturation.
`default_nettype none
module g2e_mul #(
  parameter int SHIFT = 60
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);

  localparam logic [127:0] MAG_MAX = {65'd0, {63{1'b1}}};

  logic               neg1_r, neg2_r, neg3_r;
  logic [63:0]        ua_r, ub_r;
  logic [63:0]        ua_nxt, ub_nxt;
  logic [63:0]        p00_r, p01_r, p10_r, p11_r;
  logic [127:0]       sum_r, sum_nxt;
  logic [127:0]       shf;
  logic [63:0]        mag;
  logic signed [63:0] p_r, p_nxt;

  // Operand magnitudes; the product sign is registered alongside them.
  always_comb begin
    ua_nxt = a[63] ? (64'd0 - 64'(a)) : 64'(a);
    ub_nxt = b[63] ? (64'd0 - 64'(b)) : 64'(b);
  end

  // Sum of the four partial products.
  always_comb begin
    sum_nxt = {64'd0, p00_r} + ({64'd0, p01_r} << 32) + ({64'd0, p10_r} << 32)
            + {p11_r, 64'd0};
  end

  // Scale down, clamp the magnitude and restore the sign.
  always_comb begin
    shf   = sum_r >> SHIFT;
    mag   = (shf > MAG_MAX) ? MAG_MAX[63:0] : shf[63:0];
    p_nxt = neg3_r ? (64'sd0 - $signed(mag)) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[63] ^ b[63];
      ua_r   <= ua_nxt;
      ub_r   <= ub_nxt;
      neg2_r <= neg1_r;
      p00_r  <= ua_r[31:0]  * ub_r[31:0];
      p01_r  <= ua_r[31:0]  * ub_r[63:32];
      p10_r  <= ua_r[63:32] * ub_r[31:0];
      p11_r  <= ua_r[63:32] * ub_r[63:32];
      neg3_r <= neg2_r;
      sum_r  <= sum_nxt;
      p_r    <= p_nxt;
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

/* sv/geodetic_to_ecef.sv */
// Geodetic position to Earth-centered Earth-fixed coordinates, fully pipelined.
// Usage:
//   Input beats carry latitude, longitude (binary angles, pi = 2^31) and height
//   in millimeters; output beats carry X, Y, Z in millimeters, each rounded and
//   saturated to +-8000000000. The config port sets the semi-major axis and e^2.
//   One beat is accepted every cycle while in_tready is high and one result
//   leaves per accepted beat, in order.
//   The delay from input beat to output beat is set by the CORDIC stages,
//   the eight Newton steps of the inverse square root and the multipliers.
//   Throughput is one beat per cycle while in_tready is high.
//   Reset (rst_n low, synchronous) empties the pipeline and reloads the WGS84
//   axis and eccentricity. When the receiver stalls, the output register holds
//   its beat and one more beat lands in a skid register; the pipeline then
//   freezes and in_tready drops until the skid register drains.
//   The user writes configuration only while no beat is in flight; the block does not enforce it.
`default_nettype none
module geodetic_to_ecef #(
  parameter int CORDIC_STAGES = g2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // latitude [31:0], longitude [63:32], height_mm [91:64]
  input  logic [g2e_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // ecef_x_mm [33:0], ecef_y_mm [67:34], ecef_z_mm [101:68]
  output logic [g2e_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_wen,
  input  logic [g2e_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [g2e_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  `include "geodetic_to_ecef_assert.svh"

  localparam int NS   = g2e_pkg::NEWTON_STEPS;
  localparam int ML   = g2e_pkg::MUL_LAT;
  localparam int STEP = 3 * ML + 1;
  localparam int DA   = CORDIC_STAGES + 2;
  localparam int DW   = DA + 2 * ML + 1;
  localparam int DY   = DW + STEP * NS;
  localparam int DN   = DY + ML;
  localparam int DE   = DN + 2 * ML + 1;
  localparam int HL   = DN + ML;
  localparam int TL   = DN + ML + 1 - DA;
  localparam logic signed [63:0] INV_GAIN = g2e_pkg::cordic_inv_gain(CORDIC_STAGES);
  localparam logic signed [32:0] HALF_PI  = 33'sd1073741824;
  localparam logic signed [32:0] PI_ANG   = 33'sd2147483648;

  typedef struct packed {
    logic signed [63:0] c_lat;
    logic signed [63:0] s_lat;
    logic signed [63:0] c_lon;
    logic signed [63:0] s_lon;
  } trig_t;

  // Configuration registers.
  logic [g2e_pkg::AXIS_W-1:0] axis_r;
  logic [g2e_pkg::ECC_W-1:0]  ecc_r;
  logic [g2e_pkg::ECC_W-1:0]  e2c;
  logic signed [63:0]         e2_q60, one_m_e2, axis_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= g2e_pkg::AXIS_RESET;
      ecc_r  <= g2e_pkg::ECC_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        g2e_pkg::CFG_SEMI_MAJOR: axis_r <= cfg_wdata;
        g2e_pkg::CFG_ECC_SQ:     ecc_r  <= cfg_wdata[g2e_pkg::ECC_W-1:0];
      endcase
    end
  end

  // Eccentricity saturated to one half, and the constant multiplier operands.
  always_comb begin
    e2c      = (ecc_r > g2e_pkg::ECC_LIMIT) ? g2e_pkg::ECC_LIMIT : ecc_r;
    e2_q60   = $signed({4'd0, e2c, 28'd0});
    one_m_e2 = $signed({31'd0, 33'(33'h1_0000_0000 - {1'b0, e2c})});
    axis_ext = $signed({31'd0, axis_r});
  end

  // Handshake: the pipeline moves whenever the skid register is empty.
  logic run, in_fire;
  logic v_r [DE];
  logic skid_v_r, skid_v_nxt, out_valid_r, out_valid_nxt;
  logic [g2e_pkg::OUT_DATA_W-1:0] skid_data_r, skid_data_nxt, out_data_r, out_data_nxt;
  logic [g2e_pkg::OUT_DATA_W-1:0] exit_d;

  assign run       = !skid_v_r;
  assign in_tready = run;
  assign in_fire   = in_tvalid && run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DE; j++) v_r[j] <= 1'b0;
    end else if (run) begin
      v_r[0] <= in_fire;
      for (int j = 1; j < DE; j++) v_r[j] <= v_r[j-1];
    end
  end

  // Angle folding into the CORDIC range with a sign flip of the result.
  logic signed [31:0] ang_in [2];
  logic signed [32:0] ang_ext [2];
  logic signed [32:0] ang_f [2];
  logic               flip_in [2];
  logic signed [63:0] z_in [2];

  assign ang_in[0] = $signed(in_tdata[31:0]);
  assign ang_in[1] = $signed(in_tdata[63:32]);

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      ang_ext[ch] = {ang_in[ch][31], ang_in[ch]};
      ang_f[ch]   = ang_ext[ch];
      flip_in[ch] = 1'b0;
      if (ang_ext[ch] > HALF_PI) begin
        ang_f[ch]   = ang_ext[ch] - PI_ANG;
        flip_in[ch] = 1'b1;
      end else if (ang_ext[ch] < -HALF_PI) begin
        ang_f[ch]   = ang_ext[ch] + PI_ANG;
        flip_in[ch] = 1'b1;
      end
      z_in[ch] = $signed({{31{ang_f[ch][32]}}, ang_f[ch]} << 30);
    end
  end

  // CORDIC rotation, channel 0 is latitude and channel 1 longitude.
  logic signed [63:0] atan_w [CORDIC_STAGES];
  logic signed [63:0] cx_r [2][CORDIC_STAGES+1];
  logic signed [63:0] cy_r [2][CORDIC_STAGES+1];
  logic signed [63:0] cz_r [2][CORDIC_STAGES+1];
  logic               fl_r [2][CORDIC_STAGES+1];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_atan
    localparam logic signed [63:0] ATAN = g2e_pkg::cordic_atan(i);
    assign atan_w[i] = ATAN;
  end

  always_ff @(posedge clk) begin
    if (run) begin
      for (int ch = 0; ch < 2; ch++) begin
        cx_r[ch][0] <= INV_GAIN;
        cy_r[ch][0] <= 64'sd0;
        cz_r[ch][0] <= z_in[ch];
        fl_r[ch][0] <= flip_in[ch];
        for (int i = 0; i < CORDIC_STAGES; i++) begin
          if (!cz_r[ch][i][63]) begin
            cx_r[ch][i+1] <= cx_r[ch][i] - (cy_r[ch][i] >>> i);
            cy_r[ch][i+1] <= cy_r[ch][i] + (cx_r[ch][i] >>> i);
            cz_r[ch][i+1] <= cz_r[ch][i] - atan_w[i];
          end else begin
            cx_r[ch][i+1] <= cx_r[ch][i] + (cy_r[ch][i] >>> i);
            cy_r[ch][i+1] <= cy_r[ch][i] - (cx_r[ch][i] >>> i);
            cz_r[ch][i+1] <= cz_r[ch][i] + atan_w[i];
          end
          fl_r[ch][i+1] <= fl_r[ch][i];
        end
      end
    end
  end

  // Undo the fold, then delay the sines and cosines to their products.
  trig_t trig_r, trig_nxt;
  trig_t td_r [TL];

  always_comb begin
    trig_nxt.c_lat = fl_r[0][CORDIC_STAGES] ? -cx_r[0][CORDIC_STAGES] : cx_r[0][CORDIC_STAGES];
    trig_nxt.s_lat = fl_r[0][CORDIC_STAGES] ? -cy_r[0][CORDIC_STAGES] : cy_r[0][CORDIC_STAGES];
    trig_nxt.c_lon = fl_r[1][CORDIC_STAGES] ? -cx_r[1][CORDIC_STAGES] : cx_r[1][CORDIC_STAGES];
    trig_nxt.s_lon = fl_r[1][CORDIC_STAGES] ? -cy_r[1][CORDIC_STAGES] : cy_r[1][CORDIC_STAGES];
  end

  always_ff @(posedge clk) begin
    if (run) begin
      trig_r   <= trig_nxt;
      td_r[0]  <= trig_r;
      for (int j = 1; j < TL; j++) td_r[j] <= td_r[j-1];
    end
  end

  // Height delay line from the input to the two height additions.
  logic signed [g2e_pkg::H_W-1:0] h_r [HL];

  always_ff @(posedge clk) begin
    if (run) begin
      h_r[0] <= $signed(in_tdata[64 +: g2e_pkg::H_W]);
      for (int j = 1; j < HL; j++) h_r[j] <= h_r[j-1];
    end
  end

  // w = 1 - e2 * sin^2(lat).
  logic signed [63:0] s2_w, es_w, w_r;

  g2e_mul #(.SHIFT(60)) u_s2 (
    .clk(clk), .en(run), .a(trig_r.s_lat), .b(trig_r.s_lat), .p(s2_w)
  );
  g2e_mul #(.SHIFT(60)) u_es (
    .clk(clk), .en(run), .a(e2_q60), .b(s2_w), .p(es_w)
  );

  always_ff @(posedge clk) begin
    if (run) w_r <= g2e_pkg::ONE_Q60 - es_w;
  end

  // Newton steps of the inverse square root, one pipeline section per step.
  logic signed [63:0] y_s [NS+1];
  logic signed [63:0] w_s [NS+1];

  assign y_s[0] = g2e_pkg::ONE_Q60;
  assign w_s[0] = w_r;

  for (genvar k = 0; k < NS; k++) begin : g_newton
    logic signed [63:0] y2_w, wy2_w, t_r;
    logic signed [63:0] w_d [STEP];
    logic signed [63:0] y_d [2*ML+1];

    g2e_mul #(.SHIFT(60)) u_y2 (
      .clk(clk), .en(run), .a(y_s[k]), .b(y_s[k]), .p(y2_w)
    );
    g2e_mul #(.SHIFT(60)) u_wy2 (
      .clk(clk), .en(run), .a(w_d[ML-1]), .b(y2_w), .p(wy2_w)
    );
    g2e_mul #(.SHIFT(61)) u_ny (
      .clk(clk), .en(run), .a(y_d[2*ML]), .b(t_r), .p(y_s[k+1])
    );

    always_ff @(posedge clk) begin
      if (run) begin
        t_r    <= g2e_pkg::THREE_Q60 - wy2_w;
        w_d[0] <= w_s[k];
        for (int j = 1; j < STEP; j++) w_d[j] <= w_d[j-1];
        y_d[0] <= y_s[k];
        for (int j = 1; j < 2 * ML + 1; j++) y_d[j] <= y_d[j-1];
      end
    end

    assign w_s[k+1] = w_d[STEP-1];
  end

  // Prime-vertical radius and the two radial sums, Q16 millimeters.
  logic signed [63:0] n_w, qm_w, p_r, q_r, h16_p, h16_q;

  assign h16_p = $signed({{20{h_r[DN-1][g2e_pkg::H_W-1]}}, h_r[DN-1], 16'd0});
  assign h16_q = $signed({{20{h_r[HL-1][g2e_pkg::H_W-1]}}, h_r[HL-1], 16'd0});

  g2e_mul #(.SHIFT(44)) u_n (
    .clk(clk), .en(run), .a(axis_ext), .b(y_s[NS]), .p(n_w)
  );
  g2e_mul #(.SHIFT(32)) u_q (
    .clk(clk), .en(run), .a(n_w), .b(one_m_e2), .p(qm_w)
  );

  always_ff @(posedge clk) begin
    if (run) begin
      p_r <= n_w + h16_p;
      q_r <= qm_w + h16_q;
    end
  end

  // Coordinate products.
  logic signed [63:0] pc_w, ex_w, ey_w, ez_w;

  g2e_mul #(.SHIFT(60)) u_pc (
    .clk(clk), .en(run), .a(p_r), .b(td_r[DN-DA].c_lat), .p(pc_w)
  );
  g2e_mul #(.SHIFT(60)) u_x (
    .clk(clk), .en(run), .a(pc_w), .b(td_r[TL-1].c_lon), .p(ex_w)
  );
  g2e_mul #(.SHIFT(60)) u_y (
    .clk(clk), .en(run), .a(pc_w), .b(td_r[TL-1].s_lon), .p(ey_w)
  );
  g2e_mul #(.SHIFT(60)) u_z (
    .clk(clk), .en(run), .a(q_r), .b(td_r[TL-1].s_lat), .p(ez_w)
  );

  // Round Q16 to whole millimeters (half up) and saturate.
  function automatic logic [g2e_pkg::COORD_W-1:0] finish_coord(input logic signed [63:0] v);
    logic signed [63:0] t;
    logic signed [63:0] r;
    t = v + 64'sd32768;
    r = t >>> 16;
    if (r > g2e_pkg::OUT_LIMIT) r = g2e_pkg::OUT_LIMIT;
    if (r < -g2e_pkg::OUT_LIMIT) r = -g2e_pkg::OUT_LIMIT;
    return r[g2e_pkg::COORD_W-1:0];
  endfunction

  assign exit_d = {2'b00, finish_coord(ez_w), finish_coord(ey_w), finish_coord(ex_w)};

  // Output register with a one-beat skid register behind it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    skid_v_nxt    = skid_v_r;
    skid_data_nxt = skid_data_r;
    if (skid_v_r) begin
      if (out_tready) begin
        out_data_nxt = skid_data_r;
        skid_v_nxt   = 1'b0;
      end
    end else if (!out_valid_r || out_tready) begin
      out_valid_nxt = v_r[DE-1];
      out_data_nxt  = exit_d;
    end else if (v_r[DE-1]) begin
      skid_v_nxt    = 1'b1;
      skid_data_nxt = exit_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks on the output buffering.
  `G2E_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_v_r, out_valid_r, "skid beat without output beat")
  `G2E_ASSERT_NEXT(a_stall_to_skid, clk, rst_n, out_valid_r && !out_tready && !skid_v_r && v_r[DE-1], skid_v_r, "stalled result not kept in skid")
  `G2E_ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_v_r && out_tready, !skid_v_r && out_valid_r, "skid beat not moved to output")

endmodule
`default_nettype wire
